>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GNCI_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define GNCI_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/gnci_pkg.sv
// ---------------------------------------------------------------------------
// gnci_pkg
// shared constants, register codes and probe tables of the neighbor cell unit
// ---------------------------------------------------------------------------
package gnci_pkg;

  localparam int COORD_BITS_DEF   = 16;
  localparam int GRID_DIM_MAX_DEF = 256;

  localparam int DIM_W      = 9;
  localparam int SIZE_W     = 13;
  localparam int IDX_W      = 16;
  localparam int DIR_W      = 4;
  localparam int NPROBE     = 9;
  localparam int NAXIS      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLUMNS = 3'd0,
    CFG_GRID_ROWS    = 3'd1,
    CFG_CELL_SIZE    = 3'd2,
    CFG_TILE_WIDTH   = 3'd3,
    CFG_TILE_HEIGHT  = 3'd4
  } cfg_reg_t;

  // offset per axis: none, minus one tile, plus two tiles
  typedef enum logic [1:0] {
    SEL_NONE  = 2'd0,
    SEL_MINUS = 2'd1,
    SEL_PLUS2 = 2'd2
  } probe_sel_t;

  // probe order: center, up, down, right, left, upleft, upright, downleft, downright
  localparam probe_sel_t PROBE_XSEL [NPROBE] = '{
    SEL_NONE, SEL_NONE, SEL_NONE, SEL_PLUS2, SEL_MINUS,
    SEL_MINUS, SEL_PLUS2, SEL_MINUS, SEL_PLUS2
  };
  localparam probe_sel_t PROBE_YSEL [NPROBE] = '{
    SEL_NONE, SEL_MINUS, SEL_PLUS2, SEL_NONE, SEL_NONE,
    SEL_MINUS, SEL_MINUS, SEL_PLUS2, SEL_PLUS2
  };

endpackage

>>> design/gnci_in_if.sv
// ---------------------------------------------------------------------------
// gnci_in_if
// position channel: sprite upper-left coordinates with valid/ready
// ---------------------------------------------------------------------------
interface gnci_in_if #(
  parameter int COORD_BITS = gnci_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

>>> design/gnci_out_if.sv
// ---------------------------------------------------------------------------
// gnci_out_if
// result channel: one neighbor cell index per transaction with valid/ready
// ---------------------------------------------------------------------------
interface gnci_out_if;
  import gnci_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] cell_index;
  logic [DIR_W-1:0] probe_dir;
  logic             last_cell;

  modport source (output valid, output cell_index, output probe_dir, output last_cell,
                  input ready);
  modport sink   (input valid, input cell_index, input probe_dir, input last_cell,
                  output ready);
endinterface

>>> design/gnci_cfg_if.sv
// ---------------------------------------------------------------------------
// gnci_cfg_if
// configuration write channel: register index and write data with valid/ready
// ---------------------------------------------------------------------------
interface gnci_cfg_if;
  import gnci_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/grid_neighbor_cell_indices_unit.sv
// ---------------------------------------------------------------------------
// grid_neighbor_cell_indices_unit
// neighbor cell lookup on a uniform grid, one sprite position in, 1 to 9 cells out
//
// in_ch carries a sprite's upper-left pos_x/pos_y. nine probe points around it
// are divided by cell_size, clamped to the grid and turned into linear indices.
// out_ch returns the distinct indices in probe order, each with its probe_dir,
// last_cell set on the final one of a position. cfg_ch writes the five grid
// registers (columns, rows, cell size, tile width, tile height); ready is always
// high and writes belong in idle periods only.
// path: a position passes one sum stage, one restoring divider stage per
// quotient bit, clamp, multiply, index, dedup, emit and output register.
// throughput: a position producing n distinct cells, between 1 and 9, occupies
// the result port for n transactions; single-cell positions enter back to back,
// one per cycle while out_ch accepts. once the last stage is full and the
// emitter or out_ch is busy, the whole pipeline holds still and in_ch.ready drops.
// reset: registers return to 1 column, 1 row, cell size 1, tile sizes 0, and all
// pipeline and output valid bits clear.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_neighbor_cell_indices_unit #(
  parameter int GRID_DIM_MAX = gnci_pkg::GRID_DIM_MAX_DEF,
  parameter int COORD_BITS   = gnci_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  gnci_in_if.sink    in_ch,
  gnci_out_if.source out_ch,
  gnci_cfg_if.sink   cfg_ch
);
  import gnci_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int SW   = ((CW > 15) ? CW : 15) + 1;
  localparam int MW   = SW - 1;
  localparam int NST  = MW + 5;
  localparam int NDL  = 2 * NAXIS;
  localparam int PW   = 2 * DIM_W;

  typedef struct packed {
    logic              neg;
    logic [SIZE_W-1:0] rem;
    logic [MW-1:0]     dvd;
    logic [MW-1:0]     quo;
  } div_lane_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    if (d == '0) begin
      eff_dim = DIM_W'(1);
    end else if (32'(d) > 32'(GRID_DIM_MAX)) begin
      eff_dim = DIM_W'(GRID_DIM_MAX);
    end else begin
      eff_dim = d;
    end
  endfunction

  // one restoring division step
  function automatic div_lane_t div_step(input div_lane_t a, input logic [SIZE_W-1:0] dv);
    logic [SIZE_W:0] trial;
    logic            ge;
    div_lane_t       b;
    b     = a;
    trial = {a.rem, a.dvd[MW-1]};
    ge    = (trial >= {1'b0, dv});
    b.rem = ge ? SIZE_W'(trial - {1'b0, dv}) : trial[SIZE_W-1:0];
    b.dvd = a.dvd << 1;
    b.quo = {a.quo[MW-2:0], ge};
    return b;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_cell(input div_lane_t a,
                                                   input logic [DIM_W-1:0] dim_m1);
    if (a.neg) begin
      clamp_cell = '0;
    end else if (a.quo > MW'(dim_m1)) begin
      clamp_cell = dim_m1;
    end else begin
      clamp_cell = a.quo[DIM_W-1:0];
    end
  endfunction

  // configuration registers
  logic [DIM_W-1:0]  cols_r, rows_r;
  logic [SIZE_W-1:0] cell_r, tw_r, th_r;
  logic              cfg_fire;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= DIM_W'(1);
      rows_r <= DIM_W'(1);
      cell_r <= SIZE_W'(1);
      tw_r   <= '0;
      th_r   <= '0;
    end else if (cfg_fire) begin
      case (cfg_ch.index)
        CFG_GRID_COLUMNS: cols_r <= cfg_ch.data[DIM_W-1:0];
        CFG_GRID_ROWS:    rows_r <= cfg_ch.data[DIM_W-1:0];
        CFG_CELL_SIZE:    cell_r <= cfg_ch.data[SIZE_W-1:0];
        CFG_TILE_WIDTH:   tw_r   <= cfg_ch.data[SIZE_W-1:0];
        CFG_TILE_HEIGHT:  th_r   <= cfg_ch.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0]  cols_eff, rows_eff, cols_m1, rows_m1;
  logic [SIZE_W-1:0] cell_eff;

  assign cols_eff = eff_dim(cols_r);
  assign rows_eff = eff_dim(rows_r);
  assign cols_m1  = cols_eff - DIM_W'(1);
  assign rows_m1  = rows_eff - DIM_W'(1);
  assign cell_eff = (cell_r == '0) ? SIZE_W'(1) : cell_r;

  // pipeline control: the whole pipeline moves together
  logic [NST-1:0] v_r;
  logic           en, in_fire, em_free, em_load;

  assign en          = !v_r[NST-1] || em_free;
  assign in_ch.ready = en;
  assign in_fire     = in_ch.valid && en;
  assign em_load     = v_r[NST-1] && em_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_fire};
    end
  end

  // stage: probe coordinate sums
  logic [SW-1:0] px_ext, py_ext;
  logic [SW-1:0] sum_x_r [NAXIS];
  logic [SW-1:0] sum_y_r [NAXIS];

  assign px_ext = {{(SW-CW){in_ch.pos_x[CW-1]}}, in_ch.pos_x};
  assign py_ext = {{(SW-CW){in_ch.pos_y[CW-1]}}, in_ch.pos_y};

  always_ff @(posedge clk) begin
    if (en) begin
      sum_x_r[SEL_NONE]  <= px_ext;
      sum_x_r[SEL_MINUS] <= px_ext - SW'(tw_r);
      sum_x_r[SEL_PLUS2] <= px_ext + SW'({tw_r, 1'b0});
      sum_y_r[SEL_NONE]  <= py_ext;
      sum_y_r[SEL_MINUS] <= py_ext - SW'(th_r);
      sum_y_r[SEL_PLUS2] <= py_ext + SW'({th_r, 1'b0});
    end
  end

  // divider stages: one quotient bit per stage per lane, x lanes then y lanes
  div_lane_t div_in [NDL];
  div_lane_t div_r  [MW][NDL];

  always_comb begin
    for (int a = 0; a < NAXIS; a++) begin
      // negative coordinates always land in cell zero
      div_in[a].neg         = sum_x_r[a][SW-1];
      div_in[a].rem         = '0;
      div_in[a].dvd         = sum_x_r[a][SW-1] ? '0 : sum_x_r[a][MW-1:0];
      div_in[a].quo         = '0;
      div_in[NAXIS+a].neg   = sum_y_r[a][SW-1];
      div_in[NAXIS+a].rem   = '0;
      div_in[NAXIS+a].dvd   = sum_y_r[a][SW-1] ? '0 : sum_y_r[a][MW-1:0];
      div_in[NAXIS+a].quo   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NDL; l++) begin
        div_r[0][l] <= div_step(div_in[l], cell_eff);
      end
      for (int j = 1; j < MW; j++) begin
        for (int l = 0; l < NDL; l++) begin
          div_r[j][l] <= div_step(div_r[j-1][l], cell_eff);
        end
      end
    end
  end

  // stage: clamp to the grid
  logic [DIM_W-1:0] col_r [NAXIS];
  logic [DIM_W-1:0] row_r [NAXIS];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NAXIS; a++) begin
        col_r[a] <= clamp_cell(div_r[MW-1][a], cols_m1);
        row_r[a] <= clamp_cell(div_r[MW-1][NAXIS+a], rows_m1);
      end
    end
  end

  // stage: row times columns
  logic [DIM_W-1:0] colm_r [NAXIS];
  logic [PW-1:0]    prod_r [NAXIS];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NAXIS; a++) begin
        colm_r[a] <= col_r[a];
        prod_r[a] <= PW'(row_r[a]) * PW'(cols_eff);
      end
    end
  end

  // stage: linear index per probe
  logic [IDX_W-1:0] idx_r [NPROBE];
  logic [PW-1:0]    lin   [NPROBE];

  always_comb begin
    for (int d = 0; d < NPROBE; d++) begin
      lin[d] = PW'(colm_r[PROBE_XSEL[d]]) + prod_r[PROBE_YSEL[d]];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < NPROBE; d++) begin
        idx_r[d] <= lin[d][IDX_W-1:0];
      end
    end
  end

  // stage: drop probes that repeat an earlier index
  logic [NPROBE-1:0] keep_c, keep_r;
  logic [IDX_W-1:0]  didx_r [NPROBE];

  always_comb begin
    for (int d = 0; d < NPROBE; d++) begin
      keep_c[d] = 1'b1;
      for (int k = 0; k < d; k++) begin
        if (idx_r[k] == idx_r[d]) begin
          keep_c[d] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      keep_r <= keep_c;
      for (int d = 0; d < NPROBE; d++) begin
        didx_r[d] <= idx_r[d];
      end
    end
  end

  // emitter: walks the kept probes of one position, one per output transaction
  logic [NPROBE-1:0] em_mask_r, em_mask_nxt;
  logic [IDX_W-1:0]  em_idx_r [NPROBE];
  logic [NPROBE-1:0] pick_oh, rest;
  logic [DIR_W-1:0]  pick_dir;
  logic [IDX_W-1:0]  pick_idx;
  logic              found, slot, busy, issue;

  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_idx_r;
  logic [DIR_W-1:0]  out_dir_r;
  logic              out_last_r;

  always_comb begin
    found    = 1'b0;
    pick_oh  = '0;
    pick_dir = '0;
    pick_idx = '0;
    for (int d = 0; d < NPROBE; d++) begin
      if (em_mask_r[d] && !found) begin
        found      = 1'b1;
        pick_oh[d] = 1'b1;
        pick_dir   = DIR_W'(d);
        pick_idx   = em_idx_r[d];
      end
    end
  end

  assign rest    = em_mask_r & ~pick_oh;
  assign slot    = !out_valid_r || out_ch.ready;
  assign busy    = |em_mask_r;
  assign issue   = slot && busy;
  assign em_free = !busy || (issue && (rest == '0));

  always_comb begin
    if (em_load) begin
      em_mask_nxt = keep_r;
    end else if (issue) begin
      em_mask_nxt = rest;
    end else begin
      em_mask_nxt = em_mask_r;
    end
    if (issue) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_mask_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      em_mask_r   <= em_mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (em_load) begin
      for (int d = 0; d < NPROBE; d++) begin
        em_idx_r[d] <= didx_r[d];
      end
    end
    if (issue) begin
      out_idx_r  <= pick_idx;
      out_dir_r  <= pick_dir;
      out_last_r <= (rest == '0);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_index = out_idx_r;
  assign out_ch.probe_dir  = out_dir_r;
  assign out_ch.last_cell  = out_last_r;

  // the center probe is never a duplicate
  `GNCI_ASSERT_IMP(a_center_kept, v_r[NST-1], keep_r[0])
  // a stalled pipeline keeps every valid bit in place
  `GNCI_ASSERT_NXT(a_stall_holds, !en, $stable(v_r))
  // a loaded position hands its whole keep mask to the emitter
  `GNCI_ASSERT_NXT(a_load_mask, em_load, em_mask_r == $past(keep_r))
  // every pick lands in the output register
  `GNCI_ASSERT_NXT(a_issue_valid, issue, out_valid_r)

endmodule
